FILE: rtl/rme_pkg.sv
// Package for the rotation-matrix to Euler-angle converter.
// Holds widths, CORDIC constants and the per-stage micro-rotation angle table.
// No dependencies.
`default_nettype none
package rme_pkg;
   localparam int CORDIC_STAGES = 16;
   localparam int ELEM_W = 16;
   localparam int THR_W = 15;
   localparam int SQ_W = 32;
   localparam int SY_W = 17;
   localparam int SQRT_STEPS = 16;
   localparam int XY_W = 30;
   localparam int Z_W = 24;
   localparam int ANG_W = 16;
   localparam int PITCH_W = 15;
   localparam int NUM_ATAN = 3;
   localparam logic signed [Z_W-1:0] PI_Q20 = 24'sd3294199;
   localparam logic signed [ANG_W-1:0] ROLL_LIM = 16'sd25736;
   localparam logic signed [ANG_W-1:0] PITCH_LIM = 16'sd12868;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   zero;
   } vec_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SY_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] r20;
      logic signed [ELEM_W-1:0] r21;
      logic signed [ELEM_W-1:0] r22;
      logic signed [ELEM_W-1:0] r11;
      logic signed [ELEM_W-1:0] r12;
      logic signed [ELEM_W-1:0] r00;
      logic signed [ELEM_W-1:0] r10;
      logic [THR_W-1:0]         thr;
   } hold_type;

   function automatic logic signed [Z_W-1:0] micro_angle(input int i);
      logic signed [Z_W-1:0] a;
      unique case (i)
         0: a = 24'sd823550;
         1: a = 24'sd486170;
         2: a = 24'sd256879;
         3: a = 24'sd130396;
         4: a = 24'sd65451;
         5: a = 24'sd32757;
         6: a = 24'sd16383;
         7: a = 24'sd8192;
         8: a = 24'sd4096;
         9: a = 24'sd2048;
         default: a = (i <= 20) ? Z_W'(24'sd1 <<< (20 - i)) : '0;
      endcase
      return a;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/rotation_matrix_to_euler.sv
// Rotation matrix to Z-Y-X Euler angles, top level.
// Depends on rme_pkg, rme_sqrt_cell, rme_cordic_cell.
//
// Takes one item every cycle (busy is always low) and delivers its result on
// rsp_valid through a pipeline: a chain of 16 square-root cells forms sy, a
// select register picks the angle operands, a chain of CORDIC_STAGES cells
// rotates all three vectors in parallel, and an output register rounds and
// saturates. The receiver cannot stall.
`default_nettype none
module rotation_matrix_to_euler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [rme_pkg::ELEM_W-1:0] req_r00,
   input  wire logic signed [rme_pkg::ELEM_W-1:0] req_r10,
   input  wire logic signed [rme_pkg::ELEM_W-1:0] req_r20,
   input  wire logic signed [rme_pkg::ELEM_W-1:0] req_r21,
   input  wire logic signed [rme_pkg::ELEM_W-1:0] req_r22,
   input  wire logic signed [rme_pkg::ELEM_W-1:0] req_r11,
   input  wire logic signed [rme_pkg::ELEM_W-1:0] req_r12,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rme_pkg::THR_W-1:0]         csr_data,
   output logic                                   rsp_valid,
   output logic signed [rme_pkg::ANG_W-1:0]       rsp_roll,
   output logic signed [rme_pkg::PITCH_W-1:0]     rsp_pitch,
   output logic signed [rme_pkg::ANG_W-1:0]       rsp_yaw,
   output logic                                   rsp_singular
);
   import rme_pkg::*;
   localparam int LAT = SQRT_STEPS + 1 + CORDIC_STAGES + 1;

   logic [THR_W-1:0] thr_ff;
   logic [LAT-1:0] vld_ff, vld_in;
   logic signed [SQ_W-1:0] p0, p1;

   sqrt_type sq_chain [SQRT_STEPS+1];
   hold_type hd_chain [SQRT_STEPS+1];
   vec_type  cv_chain [CORDIC_STAGES+1][NUM_ATAN];

   vec_type  sel_in [NUM_ATAN];
   vec_type  sel_ff [NUM_ATAN];
   logic     sing_in, sing_ff;
   logic     sing_pipe_ff [CORDIC_STAGES];

   logic signed [ELEM_W:0]   ay [NUM_ATAN];
   logic signed [SY_W:0]     ax [NUM_ATAN];

   logic signed [ANG_W-1:0] roll_in, roll_ff, yaw_in, yaw_ff;
   logic signed [PITCH_W-1:0] pitch_in, pitch_ff;
   logic sg_out_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
         vld_ff <= '0;
      end else begin
         if (csr_valid) thr_ff <= csr_data;
         vld_ff <= vld_in;
      end
   end
   assign vld_in = {vld_ff[LAT-2:0], start};

   assign p0 = req_r00 * req_r00;
   assign p1 = req_r10 * req_r10;
   assign sq_chain[0] = '{rem: SQ_W'(p0) + SQ_W'(p1), root: '0};
   assign hd_chain[0] = '{r20: req_r20, r21: req_r21, r22: req_r22, r11: req_r11,
                          r12: req_r12, r00: req_r00, r10: req_r10, thr: thr_ff};

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      rme_sqrt_cell u_cell (
         .clock(clock), .step(5'(g)),
         .in_sq(sq_chain[g]), .in_hold(hd_chain[g]),
         .out_sq(sq_chain[g+1]), .out_hold(hd_chain[g+1])
      );
   end

   always_comb begin
      hold_type h;
      logic [SY_W-1:0] sy;
      h = hd_chain[SQRT_STEPS];
      sy = sq_chain[SQRT_STEPS].root;
      sing_in = sy < SY_W'(h.thr);
      ay[0] = sing_in ? -(ELEM_W+1)'(h.r12) : (ELEM_W+1)'(h.r21);
      ax[0] = sing_in ? (SY_W+1)'(h.r11) : (SY_W+1)'(h.r22);
      ay[1] = -(ELEM_W+1)'(h.r20);
      ax[1] = $signed({1'b0, sy});
      ay[2] = (ELEM_W+1)'(h.r10);
      ax[2] = (SY_W+1)'(h.r00);
      for (int k = 0; k < NUM_ATAN; k++) begin
         sel_in[k].zero = (ax[k] == '0) && (ay[k] == '0);
         if (ax[k] < 0) begin
            sel_in[k].x = -(XY_W'(ax[k]) <<< 8);
            sel_in[k].y = -(XY_W'(ay[k]) <<< 8);
            sel_in[k].z = (ay[k] >= 0) ? PI_Q20 : -PI_Q20;
         end else begin
            sel_in[k].x = XY_W'(ax[k]) <<< 8;
            sel_in[k].y = XY_W'(ay[k]) <<< 8;
            sel_in[k].z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      sing_ff <= sing_in;
      sing_pipe_ff[0] <= sing_ff;
      for (int s = 1; s < CORDIC_STAGES; s++) sing_pipe_ff[s] <= sing_pipe_ff[s-1];
   end

   assign cv_chain[0] = sel_ff;
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      rme_cordic_cell u_cell (
         .clock(clock), .step(5'(g)),
         .in_vec(cv_chain[g]), .out_vec(cv_chain[g+1])
      );
   end

   function automatic logic signed [ANG_W-1:0] to_angle(input vec_type v,
                                                          input logic signed [ANG_W-1:0] lim);
      logic signed [Z_W-1:0] r;
      r = (v.z + Z_W'(64)) >>> 7;
      if (v.zero) return '0;
      if (r > Z_W'(lim)) return lim;
      if (r < -Z_W'(lim)) return -lim;
      return ANG_W'(r);
   endfunction

   always_comb begin
      roll_in = to_angle(cv_chain[CORDIC_STAGES][0], ROLL_LIM);
      pitch_in = PITCH_W'(to_angle(cv_chain[CORDIC_STAGES][1], PITCH_LIM));
      yaw_in = sing_pipe_ff[CORDIC_STAGES-1] ? '0
               : to_angle(cv_chain[CORDIC_STAGES][2], ROLL_LIM);
   end

   always_ff @(posedge clock) begin
      roll_ff <= roll_in;
      pitch_ff <= pitch_in;
      yaw_ff <= yaw_in;
      sg_out_ff <= sing_pipe_ff[CORDIC_STAGES-1];
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_roll = roll_ff;
   assign rsp_pitch = pitch_ff;
   assign rsp_yaw = yaw_ff;
   assign rsp_singular = sg_out_ff;
endmodule
`default_nettype wire

FILE: rtl/rme_sqrt_cell.sv
// One restoring square-root cell: resolves one root bit per clock.
// Depends on rme_pkg.
`default_nettype none
module rme_sqrt_cell (
   input  wire logic                 clock,
   input  wire logic [4:0]           step,
   input  wire rme_pkg::sqrt_type    in_sq,
   input  wire rme_pkg::hold_type    in_hold,
   output rme_pkg::sqrt_type         out_sq,
   output rme_pkg::hold_type         out_hold
);
   import rme_pkg::*;
   sqrt_type sq_in, sq_ff;
   hold_type hold_ff;
   logic [SQ_W+1:0] trial;
   logic [SQ_W+1:0] part;

   always_comb begin
      part = {2'b0, in_sq.rem} >> (2 * (SQRT_STEPS - 1 - step));
      trial = {{(SQ_W-SY_W){1'b0}}, in_sq.root, 2'b01};
      sq_in = in_sq;
      if (part >= trial) begin
         sq_in.rem = in_sq.rem - SQ_W'(trial << (2 * (SQRT_STEPS - 1 - step)));
         sq_in.root = SY_W'({in_sq.root, 1'b1});
      end else begin
         sq_in.root = SY_W'({in_sq.root, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      hold_ff <= in_hold;
   end
   assign out_sq = sq_ff;
   assign out_hold = hold_ff;
endmodule
`default_nettype wire

FILE: rtl/rme_cordic_cell.sv
// One CORDIC vectoring micro-rotation cell for several parallel lanes.
// Depends on rme_pkg.
`default_nettype none
module rme_cordic_cell (
   input  wire logic             clock,
   input  wire logic [4:0]       step,
   input  wire rme_pkg::vec_type in_vec [rme_pkg::NUM_ATAN],
   output rme_pkg::vec_type      out_vec [rme_pkg::NUM_ATAN]
);
   import rme_pkg::*;
   vec_type vec_in [NUM_ATAN];
   vec_type vec_ff [NUM_ATAN];
   logic signed [Z_W-1:0] ang;

   always_comb begin
      ang = micro_angle(int'(step));
      for (int k = 0; k < NUM_ATAN; k++) begin
         vec_in[k] = in_vec[k];
         if (!in_vec[k].y[XY_W-1]) begin
            vec_in[k].x = in_vec[k].x + (in_vec[k].y >>> step);
            vec_in[k].y = in_vec[k].y - (in_vec[k].x >>> step);
            vec_in[k].z = in_vec[k].z + ang;
         end else begin
            vec_in[k].x = in_vec[k].x - (in_vec[k].y >>> step);
            vec_in[k].y = in_vec[k].y + (in_vec[k].x >>> step);
            vec_in[k].z = in_vec[k].z - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end
   assign out_vec = vec_ff;
endmodule
`default_nettype wire

FILE: rtl/rme_checker.sv
// Port-level checker for rotation_matrix_to_euler, bound to the top level.
// Depends on rme_pkg.
`default_nettype none
module rme_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic signed [rme_pkg::ANG_W-1:0]  rsp_roll,
   input wire logic signed [rme_pkg::ANG_W-1:0]  rsp_yaw,
   input wire logic                              rsp_singular
);
   import rme_pkg::*;
   localparam int LAT = SQRT_STEPS + 1 + CORDIC_STAGES + 1;

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LAT rsp_valid) else $error("result missing");
   a_sing_yaw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_yaw == '0) else $error("yaw not zero");
   a_roll_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll <= ROLL_LIM && rsp_roll >= -ROLL_LIM)
      else $error("roll out of range");
endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_roll(rsp_roll), .rsp_yaw(rsp_yaw),
   .rsp_singular(rsp_singular)
);
`default_nettype wire

FILE: dv/rotation_matrix_to_euler_tb.sv
// Self-checking testbench for rotation_matrix_to_euler: drives matrix items,
// predicts Euler angles with an integer CORDIC model and checks every result.
// Depends on rme_pkg and the rotation_matrix_to_euler RTL.
`timescale 1ns / 1ps
module rotation_matrix_to_euler_tb;
   import rme_pkg::*;

   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 140;
   localparam longint PI_RAD_Q20 = 3294199;
   localparam longint ANGLE_LIM = 25736;
   localparam longint HALF_PI_LIM = 12868;
   localparam longint ATAN_Q20 [10] = '{823550, 486170, 256879, 130396, 65451,
                                        32757, 16383, 8192, 4096, 2048};

   typedef struct packed {
      logic signed [15:0] r00, r10, r20, r21, r22, r11, r12;
   } matrix_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               singular;
   } euler_type;

   typedef struct packed {
      matrix_type m;
      logic       typed;
      euler_type  want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_r00 = '0, req_r10 = '0, req_r20 = '0, req_r21 = '0;
   logic signed [15:0] req_r22 = '0, req_r11 = '0, req_r12 = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [14:0] csr_data = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_roll, rsp_yaw;
   logic signed [14:0] rsp_pitch;
   logic rsp_singular;

   euler_type angles_due[$];
   longint gimbal_thr;
   int mismatches = 0;
   int items_sent = 0;
   int singular_seen = 0;
   int idle_cycles = 0;
   logic item_taken;

   rotation_matrix_to_euler DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_r00(req_r00), .req_r10(req_r10), .req_r20(req_r20), .req_r21(req_r21),
      .req_r22(req_r22), .req_r11(req_r11), .req_r12(req_r12),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_roll(rsp_roll), .rsp_pitch(rsp_pitch),
      .rsp_yaw(rsp_yaw), .rsp_singular(rsp_singular)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic longint floor_sqrt(longint n);
      longint root, trial;
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   function automatic longint cordic_angle(longint y, longint x, longint lim);
      longint z, dx, dy, a, r;
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         z = (y >= 0) ? PI_RAD_Q20 : -PI_RAD_Q20;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (i < 10) a = ATAN_Q20[i];
         else if (i <= 20) a = longint'(1) << (20 - i);
         else a = 0;
         if (y >= 0) begin
            x += dx;
            y -= dy;
            z += a;
         end else begin
            x -= dx;
            y += dy;
            z -= a;
         end
      end
      r = (z + 64) >>> 7;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic euler_type predict_euler(matrix_type m);
      euler_type e;
      longint sy;
      sy = floor_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
      e.singular = (sy < gimbal_thr);
      e.pitch = 15'(cordic_angle(-longint'(m.r20), sy, HALF_PI_LIM));
      if (!e.singular) begin
         e.roll = 16'(cordic_angle(m.r21, m.r22, ANGLE_LIM));
         e.yaw = 16'(cordic_angle(m.r10, m.r00, ANGLE_LIM));
      end else begin
         e.roll = 16'(cordic_angle(-longint'(m.r12), m.r11, ANGLE_LIM));
         e.yaw = '0;
      end
      return e;
   endfunction

   function automatic logic signed [15:0] random_element();
      logic signed [15:0] picks [7] = '{-16'sd32768, 16'sd32767, 16'sd16384,
                                        -16'sd16384, 16'sd0, 16'sd1, -16'sd1};
      case ($urandom_range(0, 9))
         6: return picks[$urandom_range(0, 6)];
         7, 8, 9: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   task automatic send_matrix(matrix_type m, int gap, logic typed, euler_type want);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      {req_r00, req_r10, req_r20, req_r21, req_r22, req_r11, req_r12} = m;
      do @(posedge clock); while (busy);
      angles_due.push_back(typed ? want : predict_euler(m));
      items_sent++;
   endtask

   task automatic drain_and_write(logic [14:0] thr);
      @(negedge clock);
      start = 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = thr;
      do @(posedge clock); while (!csr_ready);
      gimbal_thr = thr;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         euler_type got;
         got = '{rsp_roll, rsp_pitch, rsp_yaw, rsp_singular};
         if (angles_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            euler_type want;
            want = angles_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, actual %p", want, got);
            end
            if (want.singular) singular_seen++;
         end
      end
   end

   assign item_taken = (start && !busy) || rsp_valid || (csr_valid && csr_ready);

   always @(posedge clock) begin
      if (reset || item_taken) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      dir_row_type dir_tab [12];
      logic [14:0] thr_set [5];
      matrix_type m;
      int gap;
      dir_tab = '{
         '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
           '{16'sd0, 15'sd0, 16'sd0, 1'b1}},
         '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0},
           1'b0, '0},
         '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
             16'sd32767, 16'sd32767}, 1'b0, '0},
         '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
             -16'sd32768, -16'sd32768}, 1'b0, '0},
         '{'{-16'sd16384, 16'sd0, 16'sd16384, 16'sd0, -16'sd16384, -16'sd16384,
             16'sd0}, 1'b0, '0},
         '{'{16'sd0, -16'sd16384, -16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
             16'sd16384}, 1'b0, '0},
         '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd5, -16'sd7, -16'sd16384, 16'sd16384},
           1'b0, '0},
         '{'{16'sd1, 16'sd0, -16'sd1, 16'sd0, -16'sd1, 16'sd1, -16'sd1}, 1'b0, '0},
         '{'{-16'sd1, -16'sd1, 16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'sd0}, 1'b0, '0},
         '{'{16'sd21845, -16'sd21846, 16'sd21845, -16'sd21846, 16'sd21845,
             -16'sd21846, 16'sd21845}, 1'b0, '0},
         '{'{-16'sd21846, 16'sd21845, -16'sd21846, 16'sd21845, -16'sd21846,
             16'sd21845, -16'sd21846}, 1'b0, '0},
         '{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'sd11585,
             -16'sd11585}, 1'b0, '0}
      };
      thr_set = '{15'd0, 15'd16384, 15'd32767, 15'd8000, 15'd1};
      gimbal_thr = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[k]) send_matrix(dir_tab[k].m, 0, dir_tab[k].typed, dir_tab[k].want);

      for (int phase = 0; phase < 5; phase++) begin
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            m.r00 = random_element();
            m.r10 = random_element();
            m.r20 = random_element();
            m.r21 = random_element();
            m.r22 = random_element();
            m.r11 = random_element();
            m.r12 = random_element();
            if ($urandom_range(0, 3) == 0) begin
               m.r00 = 16'($urandom_range(0, 64) - 32);
               m.r10 = 16'($urandom_range(0, 64) - 32);
            end
            gap = ((n / 40) % 2 == 0) ? 0 : $urandom_range(0, 18);
            send_matrix(m, gap, 1'b0, '0);
         end
         drain_and_write(thr_set[phase]);
      end

      @(negedge clock);
      start = 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d matrices (%0d singular) over five threshold settings.",
               items_sent, singular_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatching results", mismatches);
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
